FILE: rtl/dle_stx_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// dle_stx_frame_receiver assertion macros
// shorthand for clocked implication checks with a synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef DLE_STX_FRAME_RECEIVER_ASSERT_SVH
`define DLE_STX_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication
`define DSFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DSFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dsfr_pkg.sv
// ----------------------------------------------------------------------------
// dsfr_pkg
// types and constants shared by the frame receiver modules
// ----------------------------------------------------------------------------
`default_nettype none

package dsfr_pkg;

    localparam int unsigned HEADER_BYTES = 5;
    localparam int unsigned MAX_PAYLOAD  = 256;
    localparam int unsigned BANK_AW      = 8;
    localparam int unsigned RAM_AW       = BANK_AW + 1;
    localparam int unsigned RAM_DEPTH    = 2 ** RAM_AW;

    localparam logic [7:0] ESCAPE_RESET = 8'h10;
    localparam logic [7:0] START_RESET  = 8'h02;

    localparam logic CFG_ESCAPE = 1'b0;
    localparam logic CFG_START  = 1'b1;

    // positions inside the un-stuffed body
    localparam logic [8:0] HDR_OPCODE   = 9'd0;
    localparam logic [8:0] HDR_SEQUENCE = 9'd1;
    localparam logic [8:0] HDR_FLAGS    = 9'd2;
    localparam logic [8:0] HDR_LEN_HI   = 9'd3;
    localparam logic [8:0] HDR_SIZE     = 9'(HEADER_BYTES);
    localparam logic [8:0] FRAME_EXTRA  = 9'(HEADER_BYTES + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ARMED,
        PH_BODY,
        PH_BODY_ESC
    } rx_phase_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_GOOD   = 3'd1,
        EV_BADSUM = 3'd2,
        EV_RESYNC = 3'd3,
        EV_READ   = 3'd4
    } rx_event_t;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [RAM_AW-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        rx_event_t   event_res;
        logic [7:0]  opcode;
        logic [7:0]  seq_no;
        logic [7:0]  flags;
        logic [8:0]  length;
        logic [31:0] bad_cnt;
        logic [31:0] resync_cnt;
        logic        rd_hit;
    } rx_status_t;

endpackage

`default_nettype wire

FILE: rtl/dsfr_payload_ram.sv
// ----------------------------------------------------------------------------
// dsfr_payload_ram
// two-bank payload store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dsfr_payload_ram
    import dsfr_pkg::*;
(
    input  wire logic     aclk,
    input  wire ram_req_t ram_req,
    output logic [7:0]    rdata
);

    logic [7:0] mem [RAM_DEPTH];

    always_ff @(posedge aclk) begin
        if (ram_req.we) begin
            mem[ram_req.waddr] <= ram_req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_req.re) begin
            rdata <= mem[ram_req.raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dsfr_rx_ctrl.sv
// ----------------------------------------------------------------------------
// dsfr_rx_ctrl
// marker hunt, un-stuffing, header and checksum tracking, bank swap
// ----------------------------------------------------------------------------
`default_nettype none

`include "dle_stx_frame_receiver_assert.svh"

module dsfr_rx_ctrl
    import dsfr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       item_en,
    input  wire logic       operation,
    input  wire logic [7:0] data_byte,
    input  wire logic [7:0] read_index,
    output rx_status_t      status_next,
    output ram_req_t        ram_req
);

    logic [7:0]  escape_reg, escape_next;
    logic [7:0]  start_reg, start_next;
    rx_phase_t   phase_reg, phase_next;
    logic [8:0]  body_count_reg, body_count_next;
    logic [8:0]  needed_reg, needed_next;
    logic [7:0]  sum_reg, sum_next;
    logic        rx_bank_reg, rx_bank_next;
    logic [8:0]  good_length_reg, good_length_next;
    logic [31:0] bad_cnt_reg, bad_cnt_next;
    logic [31:0] resync_cnt_reg, resync_cnt_next;
    logic [7:0]  good_opcode_reg, good_opcode_next;
    logic [7:0]  good_sequence_reg, good_sequence_next;
    logic [7:0]  good_flags_reg, good_flags_next;
    logic [7:0]  rx_opcode_reg, rx_opcode_next;
    logic [7:0]  rx_sequence_reg, rx_sequence_next;
    logic [7:0]  rx_flags_reg, rx_flags_next;
    logic [7:0]  len_hi_reg, len_hi_next;

    logic        feed, is_esc, is_start;
    logic        take_byte, at_len, len_bad, finishing, frame_end;
    logic        frame_good, frame_bad, esc_restart, esc_abandon, resync;
    logic        restart;
    logic [8:0]  cnt_inc;
    logic [7:0]  sum_new;
    logic [15:0] len_word;

    // decode shared by both combinational blocks
    always_comb begin
        feed      = item_en && !operation;
        is_esc    = data_byte == escape_reg;
        is_start  = data_byte == start_reg;
        take_byte = feed && (((phase_reg == PH_BODY) && !is_esc) ||
                             ((phase_reg == PH_BODY_ESC) && is_esc));
        cnt_inc   = body_count_reg + 9'd1;
        sum_new   = sum_reg + data_byte;
        len_word  = {len_hi_reg, data_byte};
        at_len    = cnt_inc == HDR_SIZE;
        len_bad   = at_len && (len_word > 16'(MAX_PAYLOAD));
        // needed count is zero until the length is known, so no early match
        finishing = !at_len && (cnt_inc == needed_reg);
        frame_end = len_bad || finishing;
        frame_good  = take_byte && finishing && (sum_new == 8'd0);
        frame_bad   = take_byte && finishing && (sum_new != 8'd0);
        esc_restart = feed && (phase_reg == PH_BODY_ESC) && !is_esc && is_start;
        esc_abandon = feed && (phase_reg == PH_BODY_ESC) && !is_esc && !is_start;
        resync      = esc_restart || esc_abandon || (take_byte && len_bad);
        restart     = (feed && (phase_reg == PH_ARMED) && !is_esc && is_start) ||
                      esc_restart || esc_abandon || (take_byte && frame_end);
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (feed) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (is_esc) phase_next = PH_ARMED;
                end
                PH_ARMED: begin
                    if (is_esc)        phase_next = PH_ARMED;
                    else if (is_start) phase_next = PH_BODY;
                    else               phase_next = PH_IDLE;
                end
                PH_BODY: begin
                    if (is_esc)         phase_next = PH_BODY_ESC;
                    else if (frame_end) phase_next = PH_IDLE;
                    else                phase_next = PH_BODY;
                end
                PH_BODY_ESC: begin
                    if (is_esc)        phase_next = frame_end ? PH_IDLE : PH_BODY;
                    else if (is_start) phase_next = PH_BODY;
                    else               phase_next = PH_IDLE;
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // datapath, counters and outputs
    always_comb begin
        escape_next        = escape_reg;
        start_next         = start_reg;
        body_count_next    = body_count_reg;
        needed_next        = needed_reg;
        sum_next           = sum_reg;
        rx_bank_next       = rx_bank_reg;
        good_length_next   = good_length_reg;
        bad_cnt_next       = bad_cnt_reg;
        resync_cnt_next    = resync_cnt_reg;
        good_opcode_next   = good_opcode_reg;
        good_sequence_next = good_sequence_reg;
        good_flags_next    = good_flags_reg;
        rx_opcode_next     = rx_opcode_reg;
        rx_sequence_next   = rx_sequence_reg;
        rx_flags_next      = rx_flags_reg;
        len_hi_next        = len_hi_reg;

        if (cfg_wr_en) begin
            if (cfg_index == CFG_ESCAPE) escape_next = cfg_data;
            if (cfg_index == CFG_START)  start_next  = cfg_data;
        end

        if (restart) begin
            body_count_next = 9'd0;
            needed_next     = 9'd0;
            sum_next        = 8'd0;
        end else if (take_byte) begin
            body_count_next = cnt_inc;
            sum_next        = sum_new;
            if (at_len) needed_next = len_word[8:0] + FRAME_EXTRA;
        end

        if (take_byte) begin
            case (body_count_reg)
                HDR_OPCODE:   rx_opcode_next   = data_byte;
                HDR_SEQUENCE: rx_sequence_next = data_byte;
                HDR_FLAGS:    rx_flags_next    = data_byte;
                HDR_LEN_HI:   len_hi_next      = data_byte;
                default:      ;
            endcase
        end

        if (frame_good) begin
            good_opcode_next   = rx_opcode_reg;
            good_sequence_next = rx_sequence_reg;
            good_flags_next    = rx_flags_reg;
            good_length_next   = needed_reg - FRAME_EXTRA;
            rx_bank_next       = !rx_bank_reg;
        end
        if (frame_bad) bad_cnt_next    = bad_cnt_reg + 32'd1;
        if (resync)    resync_cnt_next = resync_cnt_reg + 32'd1;

        // payload bytes go to the receive bank, the checksum byte is not kept
        ram_req.we    = take_byte && (body_count_reg >= HDR_SIZE) && !finishing;
        ram_req.waddr = {rx_bank_reg, BANK_AW'(body_count_reg - HDR_SIZE)};
        ram_req.wdata = data_byte;
        ram_req.re    = item_en && operation;
        ram_req.raddr = {!rx_bank_reg, read_index};

        if (operation)       status_next.event_res = EV_READ;
        else if (resync)     status_next.event_res = EV_RESYNC;
        else if (frame_good) status_next.event_res = EV_GOOD;
        else if (frame_bad)  status_next.event_res = EV_BADSUM;
        else                 status_next.event_res = EV_NONE;
        status_next.opcode     = good_opcode_next;
        status_next.seq_no     = good_sequence_next;
        status_next.flags      = good_flags_next;
        status_next.length     = good_length_next;
        status_next.bad_cnt    = bad_cnt_next;
        status_next.resync_cnt = resync_cnt_next;
        status_next.rd_hit     = operation && ({1'b0, read_index} < good_length_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_reg        <= ESCAPE_RESET;
            start_reg         <= START_RESET;
            phase_reg         <= PH_IDLE;
            body_count_reg    <= 9'd0;
            needed_reg        <= 9'd0;
            sum_reg           <= 8'd0;
            rx_bank_reg       <= 1'b0;
            good_length_reg   <= 9'd0;
            bad_cnt_reg       <= 32'd0;
            resync_cnt_reg    <= 32'd0;
            good_opcode_reg   <= 8'd0;
            good_sequence_reg <= 8'd0;
            good_flags_reg    <= 8'd0;
        end else begin
            escape_reg        <= escape_next;
            start_reg         <= start_next;
            phase_reg         <= phase_next;
            body_count_reg    <= body_count_next;
            needed_reg        <= needed_next;
            sum_reg           <= sum_next;
            rx_bank_reg       <= rx_bank_next;
            good_length_reg   <= good_length_next;
            bad_cnt_reg       <= bad_cnt_next;
            resync_cnt_reg    <= resync_cnt_next;
            good_opcode_reg   <= good_opcode_next;
            good_sequence_reg <= good_sequence_next;
            good_flags_reg    <= good_flags_next;
        end
    end

    // header bytes of the frame in flight
    always_ff @(posedge aclk) begin
        rx_opcode_reg   <= rx_opcode_next;
        rx_sequence_reg <= rx_sequence_next;
        rx_flags_reg    <= rx_flags_next;
        len_hi_reg      <= len_hi_next;
    end

    `DSFR_ASSERT_IMP(a_needed_ahead, aclk, aresetn, body_count_reg > HDR_SIZE,
        needed_reg > body_count_reg, "body count ran past the frame length")
    `DSFR_ASSERT_IMP(a_length_limit, aclk, aresetn, 1'b1,
        good_length_reg <= 9'(MAX_PAYLOAD), "stored length above maximum")
    `DSFR_ASSERT_NXT(a_bank_swap, aclk, aresetn, frame_good,
        rx_bank_reg != $past(rx_bank_reg), "bank not swapped on good frame")
    `DSFR_ASSERT_NXT(a_resync_count, aclk, aresetn, resync,
        resync_cnt_reg == $past(resync_cnt_reg) + 32'd1, "resync not counted")
    `DSFR_ASSERT_IMP(a_write_rx_bank, aclk, aresetn, ram_req.we,
        !ram_req.re && (ram_req.waddr[RAM_AW-1] == rx_bank_reg),
        "payload write outside the receive bank")

endmodule

`default_nettype wire

FILE: rtl/dle_stx_frame_receiver.sv
// Byte-stuffed frame receiver with payload read-back.
// Input channel (s_*): one request per item. s_operation 0 feeds s_data_byte
// as a received line byte, 1 reads the payload byte at s_read_index of the
// last good frame (zero at or past its length).
// Result channel (m_*): exactly one result per request, in order. Each result
// carries the event code and the header, length and counters as they stand
// after that request.
// Configuration: cfg_wr_en writes cfg_data to the escape (index 0) or start
// (index 1) byte at once; write only while no request is in flight.
// Pipeline: the first stage, with the memory read, then the output register.
// Throughput: one request per cycle while m_ready is high; the payload memory
// has separate write and read ports and the two banks keep receive writes
// apart from read-back.
// Reset (aresetn low, synchronous): hunting for the marker, counters, length
// and header cleared, escape 0x10, start 0x02; no memory clearing is needed.
// When m_ready is low, the output register and one stage behind it fill up,
// then s_ready drops until results drain.
// ----------------------------------------------------------------------------
// dle_stx_frame_receiver
// top level: request pipeline, result register and payload memory
// ----------------------------------------------------------------------------
`default_nettype none

module dle_stx_frame_receiver
    import dsfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic [7:0]  s_read_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_event_res,
    output logic [7:0]       m_frame_opcode,
    output logic [7:0]       m_frame_sequence,
    output logic [7:0]       m_frame_flags,
    output logic [8:0]       m_payload_length,
    output logic [7:0]       m_payload_byte,
    output logic [31:0]      m_bad_checksum_count,
    output logic [31:0]      m_resync_count
);

    rx_status_t  status_next;
    ram_req_t    ram_req;
    logic [7:0]  ram_rdata;

    logic        accept, s1_move, out_load;
    logic        s1_valid_reg, s1_valid_next;
    rx_status_t  s1_status_reg;
    logic        m_valid_reg, m_valid_next;
    rx_status_t  m_status_reg;
    logic [7:0]  m_byte_reg;

    dsfr_rx_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_en     (accept),
        .operation   (s_operation),
        .data_byte   (s_data_byte),
        .read_index  (s_read_index),
        .status_next (status_next),
        .ram_req     (ram_req)
    );

    dsfr_payload_ram u_ram (
        .aclk    (aclk),
        .ram_req (ram_req),
        .rdata   (ram_rdata)
    );

    always_comb begin
        s1_move  = !m_valid_reg || m_ready;
        s_ready  = !s1_valid_reg || s1_move;
        accept   = s_valid && s_ready;
        out_load = s1_valid_reg && s1_move;

        if (accept)       s1_valid_next = 1'b1;
        else if (s1_move) s1_valid_next = 1'b0;
        else              s1_valid_next = s1_valid_reg;

        if (out_load)     m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
        else              m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // memory read data lines up with the first stage
    always_ff @(posedge aclk) begin
        if (accept) s1_status_reg <= status_next;
        if (out_load) begin
            m_status_reg <= s1_status_reg;
            m_byte_reg   <= s1_status_reg.rd_hit ? ram_rdata : 8'd0;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_event_res          = m_status_reg.event_res;
    assign m_frame_opcode       = m_status_reg.opcode;
    assign m_frame_sequence     = m_status_reg.seq_no;
    assign m_frame_flags        = m_status_reg.flags;
    assign m_payload_length     = m_status_reg.length;
    assign m_payload_byte       = m_byte_reg;
    assign m_bad_checksum_count = m_status_reg.bad_cnt;
    assign m_resync_count       = m_status_reg.resync_cnt;

endmodule

`default_nettype wire

FILE: sim/tb_dle_stx_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_dle_stx_frame_receiver
// self-checking bench: line bytes and read-back requests go in through a
// queue-fed driver, and every result is checked against a local model of the
// deframer, under several escape and start settings and random back-pressure
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dle_stx_frame_receiver;
    import dsfr_pkg::*;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;
    localparam int unsigned STORE_DEPTH = HEADER_BYTES + MAX_PAYLOAD + 1;
    localparam int WATCHDOG_LIMIT = 400;

    typedef enum int {
        FAULT_NONE,
        FAULT_SUM,
        FAULT_CUT
    } frame_fault_t;

    typedef struct {
        logic       op;
        logic [7:0] data;
        logic [7:0] read_idx;
    } line_request_t;

    typedef struct {
        rx_event_t   ev;
        logic [7:0]  opcode;
        logic [7:0]  seq_no;
        logic [7:0]  flags;
        logic [8:0]  length;
        logic [7:0]  pbyte;
        logic [31:0] bad_cnt;
        logic [31:0] resync_cnt;
    } rx_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_ESCAPE;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = OP_FEED;
    logic [7:0]  s_data_byte = 8'h00;
    logic [7:0]  s_read_index = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_event_res;
    logic [7:0]  m_frame_opcode;
    logic [7:0]  m_frame_sequence;
    logic [7:0]  m_frame_flags;
    logic [8:0]  m_payload_length;
    logic [7:0]  m_payload_byte;
    logic [31:0] m_bad_checksum_count;
    logic [31:0] m_resync_count;

    dle_stx_frame_receiver uut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_operation          (s_operation),
        .s_data_byte          (s_data_byte),
        .s_read_index         (s_read_index),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_event_res          (m_event_res),
        .m_frame_opcode       (m_frame_opcode),
        .m_frame_sequence     (m_frame_sequence),
        .m_frame_flags        (m_frame_flags),
        .m_payload_length     (m_payload_length),
        .m_payload_byte       (m_payload_byte),
        .m_bad_checksum_count (m_bad_checksum_count),
        .m_resync_count       (m_resync_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // deframer model: own copy of settings and receive state
    // ------------------------------------------------------------------------
    logic [7:0]  mdl_esc = ESCAPE_RESET;
    logic [7:0]  mdl_stx = START_RESET;
    rx_phase_t   rx_phase = PH_IDLE;
    int unsigned body_cnt = 0;
    int unsigned need_cnt = 0;
    logic [7:0]  run_sum = 8'h00;
    logic [7:0]  body_mem [STORE_DEPTH];
    logic [8:0]  good_len = 9'd0;
    logic [31:0] fail_cnt = 32'd0;
    logic [31:0] resync_cnt = 32'd0;
    logic [7:0]  lat_opcode = 8'h00;
    logic [7:0]  lat_seq = 8'h00;
    logic [7:0]  lat_flags = 8'h00;
    logic [7:0]  lat_payload [MAX_PAYLOAD];

    function automatic void clear_body();
        body_cnt = 0;
        need_cnt = 0;
        run_sum = 8'h00;
    endfunction

    function automatic rx_event_t drop_frame();
        rx_phase = PH_IDLE;
        clear_body();
        resync_cnt++;
        return EV_RESYNC;
    endfunction

    function automatic rx_event_t absorb_byte(logic [7:0] b);
        rx_event_t   ev;
        int unsigned plen;
        ev = EV_NONE;
        body_mem[body_cnt] = b;
        body_cnt++;
        run_sum += b;
        if (body_cnt == HEADER_BYTES) begin
            plen = {body_mem[3], body_mem[4]};
            if (plen > MAX_PAYLOAD)
                return drop_frame();
            need_cnt = HEADER_BYTES + plen + 1;
        end
        if (body_cnt >= HEADER_BYTES && body_cnt == need_cnt) begin
            if (run_sum != 8'h00) begin
                fail_cnt++;
                ev = EV_BADSUM;
            end else begin
                plen = need_cnt - HEADER_BYTES - 1;
                lat_opcode = body_mem[0];
                lat_seq = body_mem[1];
                lat_flags = body_mem[2];
                for (int i = 0; i < plen; i++)
                    lat_payload[i] = body_mem[HEADER_BYTES + i];
                good_len = 9'(plen);
                ev = EV_GOOD;
            end
            rx_phase = PH_IDLE;
            clear_body();
        end
        return ev;
    endfunction

    function automatic rx_event_t feed_byte(logic [7:0] b);
        rx_event_t ev;
        ev = EV_NONE;
        case (rx_phase)
            PH_IDLE: begin
                if (b == mdl_esc)
                    rx_phase = PH_ARMED;
            end
            PH_ARMED: begin
                // escape wins when escape and start are equal
                if (b != mdl_esc) begin
                    if (b == mdl_stx) begin
                        rx_phase = PH_BODY;
                        clear_body();
                    end else begin
                        rx_phase = PH_IDLE;
                    end
                end
            end
            PH_BODY: begin
                if (b == mdl_esc)
                    rx_phase = PH_BODY_ESC;
                else
                    ev = absorb_byte(b);
            end
            default: begin
                rx_phase = PH_BODY;
                if (b == mdl_esc) begin
                    ev = absorb_byte(mdl_esc);
                end else if (b == mdl_stx) begin
                    // fresh marker mid-body restarts at once
                    clear_body();
                    resync_cnt++;
                    ev = EV_RESYNC;
                end else begin
                    ev = drop_frame();
                end
            end
        endcase
        return ev;
    endfunction

    function automatic rx_result_t predict_result(logic op, logic [7:0] d, logic [7:0] idx);
        rx_result_t r;
        r.pbyte = 8'h00;
        if (op == OP_FEED) begin
            r.ev = feed_byte(d);
        end else begin
            r.ev = EV_READ;
            if (idx < good_len)
                r.pbyte = lat_payload[idx];
        end
        r.opcode = lat_opcode;
        r.seq_no = lat_seq;
        r.flags = lat_flags;
        r.length = good_len;
        r.bad_cnt = fail_cnt;
        r.resync_cnt = resync_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // request source
    // ------------------------------------------------------------------------
    line_request_t byte_requests [$];
    rx_result_t    results_due [$];
    logic [7:0]    gen_esc = ESCAPE_RESET;
    logic [7:0]    gen_stx = START_RESET;
    int            requests_queued = 0;
    int            settings_used = 1;

    function automatic logic [7:0] line_byte();
        return ($urandom_range(0, 5) == 0) ? gen_esc : 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_index();
        return $urandom_range(0, 1) ? 8'($urandom_range(0, 20)) : 8'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned short_len();
        return ($urandom_range(0, 39) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
    endfunction

    task automatic push_request(logic op, logic [7:0] d, logic [7:0] idx);
        line_request_t q;
        q.op = op;
        q.data = d;
        q.read_idx = idx;
        byte_requests.push_back(q);
        requests_queued++;
    endtask

    task automatic push_feed(logic [7:0] b);
        push_request(OP_FEED, b, 8'($urandom));
    endtask

    task automatic push_read(logic [7:0] idx);
        push_request(OP_READ, 8'($urandom), idx);
    endtask

    // one un-stuffed body byte, with the odd read slipped in mid-frame
    task automatic push_body(logic [7:0] b);
        if ($urandom_range(0, 19) == 0)
            push_read(pick_index());
        push_feed(b);
        if (b == gen_esc)
            push_feed(b);
    endtask

    task automatic send_frame(int unsigned plen, frame_fault_t fault);
        logic [7:0] body [$];
        logic [7:0] sum;
        logic [7:0] other;
        int         cut_at;
        sum = 8'h00;
        repeat (3) body.push_back(line_byte());
        body.push_back(8'(plen >> 8));
        body.push_back(8'(plen));
        if (plen <= MAX_PAYLOAD) begin
            repeat (plen) body.push_back(line_byte());
            foreach (body[i]) sum += body[i];
            if (fault == FAULT_SUM)
                body.push_back(8'h00 - sum + 8'($urandom_range(1, 255)));
            else
                body.push_back(8'h00 - sum);
        end
        cut_at = (fault == FAULT_CUT) ? $urandom_range(0, body.size() - 1) : body.size();
        push_feed(gen_esc);
        push_feed(gen_stx);
        for (int i = 0; i < cut_at; i++)
            push_body(body[i]);
        if (fault == FAULT_CUT) begin
            push_feed(gen_esc);
            if ($urandom_range(0, 1)) begin
                push_feed(gen_stx);
            end else begin
                do other = 8'($urandom); while (other == gen_esc || other == gen_stx);
                push_feed(other);
            end
        end
    endtask

    task automatic random_phase(int budget);
        int goal;
        int pick;
        goal = requests_queued + budget;
        while (requests_queued < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_frame(short_len(), FAULT_NONE);
            end else if (pick < 65) begin
                send_frame(short_len(), FAULT_SUM);
            end else if (pick < 75) begin
                send_frame(short_len(), FAULT_CUT);
            end else if (pick < 82) begin
                if ($urandom_range(0, 3) == 0)
                    send_frame(MAX_PAYLOAD + 1, FAULT_NONE);
                else
                    send_frame($urandom_range(MAX_PAYLOAD + 1, 65535), FAULT_NONE);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 2))
                        0: push_feed(gen_esc);
                        1: push_feed(gen_stx);
                        default: push_feed(8'($urandom));
                    endcase
                end
            end else begin
                repeat ($urandom_range(1, 4)) push_read(pick_index());
            end
        end
    endtask

    task automatic wait_drain();
        do @(negedge aclk);
        while (byte_requests.size() != 0 || s_valid || results_due.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_config(logic [7:0] esc, logic [7:0] stx);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ESCAPE;
        cfg_data <= esc;
        @(posedge aclk);
        cfg_index <= CFG_START;
        cfg_data <= stx;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mdl_esc = esc;
        mdl_stx = stx;
        gen_esc = esc;
        gen_stx = stx;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // driver and result sink
    // ------------------------------------------------------------------------
    int gap_left = 0;
    bit src_calm = 1'b0;
    int stall_left = 0;
    bit sink_calm = 1'b0;

    always @(posedge aclk) begin
        line_request_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                s_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (byte_requests.size() != 0) begin
                nxt = byte_requests.pop_front();
                s_valid <= 1'b1;
                s_operation <= nxt.op;
                s_data_byte <= nxt.data;
                s_read_index <= nxt.read_idx;
                if ($urandom_range(0, 39) == 0)
                    src_calm <= !src_calm;
                gap_left <= src_calm ? 0 : $urandom_range(0, 14);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        int w;
        if (m_valid && m_ready && aresetn) begin
            if ($urandom_range(0, 39) == 0)
                sink_calm <= !sink_calm;
            w = sink_calm ? 0 : $urandom_range(0, 14);
            m_ready <= (w == 0);
            stall_left <= w;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= (stall_left == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor and checks
    // ------------------------------------------------------------------------
    int errors = 0;
    int checked = 0;
    int n_good = 0;
    int n_badsum = 0;
    int n_resync = 0;
    int n_read = 0;

    task automatic report_mismatch(string msg);
        $display("MISMATCH %s", msg);
        errors++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                      checked, name, got, want));
    endtask

    always @(posedge aclk) begin
        rx_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                              checked));
                end else begin
                    want = results_due.pop_front();
                    check_field("event", 32'(m_event_res), 32'(want.ev));
                    check_field("opcode", 32'(m_frame_opcode), 32'(want.opcode));
                    check_field("sequence", 32'(m_frame_sequence), 32'(want.seq_no));
                    check_field("flags", 32'(m_frame_flags), 32'(want.flags));
                    check_field("length", 32'(m_payload_length), 32'(want.length));
                    check_field("payload byte", 32'(m_payload_byte), 32'(want.pbyte));
                    check_field("bad checksum count", m_bad_checksum_count, want.bad_cnt);
                    check_field("resync count", m_resync_count, want.resync_cnt);
                    case (want.ev)
                        EV_GOOD:   n_good++;
                        EV_BADSUM: n_badsum++;
                        EV_RESYNC: n_resync++;
                        EV_READ:   n_read++;
                        default:   ;
                    endcase
                end
                checked++;
            end
            if (s_valid && s_ready)
                results_due.push_back(predict_result(s_operation, s_data_byte, s_read_index));
        end
    end

    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no request or result moved for %0d cycles", idle_cycles);
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] esc;
        logic [7:0] stx;
        foreach (lat_payload[i]) lat_payload[i] = 8'h00;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // armed, then a byte that is neither escape nor start
        push_feed(ESCAPE_RESET);
        push_feed(8'h55);
        // doubled escape keeps the receiver armed
        push_feed(ESCAPE_RESET);
        push_feed(ESCAPE_RESET);
        push_feed(START_RESET);
        // literal escape as opcode, then a fresh marker inside the body
        push_feed(ESCAPE_RESET);
        push_feed(ESCAPE_RESET);
        push_feed(ESCAPE_RESET);
        push_feed(START_RESET);
        // header length 0x0101 is over the limit
        push_feed(8'hFF);
        push_feed(8'h00);
        push_feed(8'h01);
        push_feed(8'h01);
        push_feed(8'h01);
        // empty good frame, then reads past its length
        push_feed(ESCAPE_RESET);
        push_feed(START_RESET);
        push_feed(8'hAA);
        push_feed(8'h55);
        push_feed(8'h00);
        push_feed(8'h00);
        push_feed(8'h00);
        push_feed(8'h01);
        push_read(8'h00);
        push_read(8'hFF);
        // escape followed by a stray byte inside a body
        push_feed(ESCAPE_RESET);
        push_feed(START_RESET);
        push_feed(ESCAPE_RESET);
        push_feed(8'h77);
        wait_drain();

        // one full-size frame so every read index can hit
        send_frame(MAX_PAYLOAD, FAULT_NONE);
        repeat (12) push_read(8'($urandom));
        push_read(8'hFF);
        random_phase(40);
        wait_drain();

        set_config(8'h00, 8'hFF);
        random_phase(120);
        wait_drain();

        set_config(8'hFF, 8'h00);
        random_phase(120);
        wait_drain();

        // escape equal to start: no frame can ever open
        set_config(8'h5A, 8'h5A);
        random_phase(50);
        wait_drain();

        esc = 8'($urandom);
        do stx = 8'($urandom); while (stx == esc);
        set_config(esc, stx);
        random_phase(140);
        wait_drain();

        set_config(ESCAPE_RESET, START_RESET);
        random_phase(70);
        wait_drain();
        repeat (8) @(negedge aclk);

        $display("covered %0d requests over %0d escape/start settings, %0d results checked",
                 requests_queued, settings_used, checked);
        $display("events seen: %0d good, %0d bad checksum, %0d resync, %0d read replies",
                 n_good, n_badsum, n_resync, n_read);
        if (errors == 0 && results_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
